>>> rtl/pasb_pkg.sv
`default_nettype none
package pasb_pkg;
	localparam int COORD_W = 24;
	localparam int DIFF_W = 25;
	localparam int INDEX_W = 20;
	localparam int SECTOR_W = 8;
	localparam int DIST_W = 25;
	localparam int COUNT_W = 9;
	localparam int CORDIC_STEPS = 30;
	localparam int CW = 60;
	localparam int SQ_W = 52;
	localparam int SQRT_STEPS = 26;
	localparam int MAX_SECTORS_DEF = 256;
	localparam int AFB_DEF = 16;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [1:0] REG_ORIGIN_X = 2'd0;
	localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
	localparam logic [1:0] REG_ORIGIN_Z = 2'd2;
	localparam logic [1:0] REG_SECTOR_COUNT = 2'd3;

	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] t;
		unique case (i)
			0: t = 32'h20000000; 1: t = 32'h12E4051E; 2: t = 32'h09FB385B;
			3: t = 32'h051111D4; 4: t = 32'h028B0D43; 5: t = 32'h0145D7E1;
			6: t = 32'h00A2F61E; 7: t = 32'h00517C55; 8: t = 32'h0028BE53;
			9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
			12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
			15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
			18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
			21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
			24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
			27: t = 32'h00000005; 28: t = 32'h00000003; 29: t = 32'h00000001;
			default: t = 32'h0;
		endcase
		return t;
	endfunction

	typedef struct packed {
		logic [INDEX_W-1:0] idx;
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
		logic signed [DIFF_W-1:0] dz;
		logic [COUNT_W+3:0] count;
	} pasb_item_t;

	typedef struct packed {
		logic [INDEX_W-1:0] idx;
		logic [SECTOR_W-1:0] sector;
		logic [DIST_W-1:0] distance;
		logic signed [DIFF_W-1:0] elev;
	} pasb_result_t;

	typedef struct packed {
		logic push;
		logic full;
	} pasb_queue_ctl_t;
endpackage
`default_nettype wire

>>> rtl/pasb_front.sv
`default_nettype none
module pasb_front #(
	parameter int MAX_SECTORS = pasb_pkg::MAX_SECTORS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [pasb_pkg::COORD_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [pasb_pkg::INDEX_W-1:0] in_idx,
	input wire logic [pasb_pkg::COORD_W-1:0] in_x,
	input wire logic [pasb_pkg::COORD_W-1:0] in_y,
	input wire logic [pasb_pkg::COORD_W-1:0] in_z,
	input wire pasb_pkg::pasb_queue_ctl_t qctl_in,
	output pasb_pkg::pasb_queue_ctl_t qctl_out,
	output pasb_pkg::pasb_item_t item
);
	import pasb_pkg::*;
	logic signed [COORD_W-1:0] ox_q, oy_q, oz_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [COUNT_W+3:0] cnt_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ox_q <= '0; oy_q <= '0; oz_q <= '0;
			cnt_q <= COUNT_W'(8);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORIGIN_X: ox_q <= cfg_data;
				REG_ORIGIN_Y: oy_q <= cfg_data;
				REG_ORIGIN_Z: oz_q <= cfg_data;
				REG_SECTOR_COUNT: cnt_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (cnt_q == '0) cnt_eff = (COUNT_W+4)'(1);
		else if ({4'b0, cnt_q} > (COUNT_W+4)'(MAX_SECTORS)) cnt_eff = (COUNT_W+4)'(MAX_SECTORS);
		else cnt_eff = {4'b0, cnt_q};
	end

	assign in_ready = !qctl_in.full;
	assign qctl_out.push = in_valid && in_ready;
	assign qctl_out.full = 1'b0;
	assign item.idx = in_idx;
	assign item.dx = DIFF_W'($signed(in_x)) - DIFF_W'(ox_q);
	assign item.dy = DIFF_W'($signed(in_y)) - DIFF_W'(oy_q);
	assign item.dz = DIFF_W'($signed(in_z)) - DIFF_W'(oz_q);
	assign item.count = cnt_eff;
endmodule
`default_nettype wire

>>> rtl/pasb_queue.sv
`default_nettype none
module pasb_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire pasb_pkg::pasb_queue_ctl_t ctl_in,
	output pasb_pkg::pasb_queue_ctl_t ctl_out,
	input wire pasb_pkg::pasb_item_t wr_item,
	output logic rd_valid,
	input wire logic rd_pop,
	output pasb_pkg::pasb_item_t rd_item
);
	import pasb_pkg::*;
	localparam int AW = $clog2(QUEUE_DEPTH);
	pasb_item_t mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] n_q;
	logic push, pop;

	assign push = ctl_in.push;
	assign pop = rd_pop && rd_valid;
	assign rd_valid = n_q != '0;
	assign rd_item = mem_q[rp_q];
	assign ctl_out.full = n_q == (AW+1)'(QUEUE_DEPTH);
	assign ctl_out.push = 1'b0;

	always_ff @(posedge clk) if (push) mem_q[wp_q] <= wr_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; n_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			n_q <= n_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule
`default_nettype wire

>>> rtl/pasb_back.sv
`default_nettype none
module pasb_back #(
	parameter int ANGLE_FRACTION_BITS = pasb_pkg::AFB_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	output logic q_pop,
	input wire pasb_pkg::pasb_item_t q_item,
	output logic out_valid,
	input wire logic out_ready,
	output pasb_pkg::pasb_result_t out_res
);
	import pasb_pkg::*;
	localparam int AFB = ANGLE_FRACTION_BITS;
	localparam int NS = CORDIC_STEPS + 3;
	localparam int PW = AFB + 1 + COUNT_W + 4;

	// stage 0 prerotation, stages 1..30 cordic and sqrt, then rounding, product, clamp
	logic v_s [NS+1];
	pasb_item_t it_s [NS+1];
	logic signed [CW-1:0] x_s [CORDIC_STEPS+1];
	logic signed [CW-1:0] y_s [CORDIC_STEPS+1];
	logic [31:0] z_s [CORDIC_STEPS+1];
	logic [SQ_W-1:0] rem_s [CORDIC_STEPS+1];
	logic [SQ_W-1:0] res_s [CORDIC_STEPS+1];
	logic [AFB:0] a_s32;
	logic [PW-1:0] p_s33;
	logic [DIST_W-1:0] d_s32, d_s33;
	logic zr_s32, zr_s33;
	logic stall;
	logic adv;

	assign stall = v_s[NS] && !out_ready;
	assign adv = !stall;
	assign q_pop = adv && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NS; k++) v_s[k] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= q_valid;
			for (int k = 1; k <= NS; k++) v_s[k] <= v_s[k-1];
		end
	end

	logic [DIFF_W-1:0] ax, ay, az;
	assign ax = q_item.dx < 0 ? DIFF_W'(-q_item.dx) : q_item.dx;
	assign ay = q_item.dy < 0 ? DIFF_W'(-q_item.dy) : q_item.dy;
	assign az = q_item.dz < 0 ? DIFF_W'(-q_item.dz) : q_item.dz;

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s[0] <= q_item;
			for (int k = 1; k <= NS; k++) it_s[k] <= it_s[k-1];
			if (q_item.dx < 0) begin
				x_s[0] <= CW'(-q_item.dx) <<< 32;
				y_s[0] <= CW'(-q_item.dy) <<< 32;
				z_s[0] <= 32'h80000000;
			end else begin
				x_s[0] <= CW'(q_item.dx) <<< 32;
				y_s[0] <= CW'(q_item.dy) <<< 32;
				z_s[0] <= 32'h0;
			end
			rem_s[0] <= SQ_W'(ax) * SQ_W'(ax) + SQ_W'(ay) * SQ_W'(ay) + SQ_W'(az) * SQ_W'(az);
			res_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		localparam int BP = (i < SQRT_STEPS) ? 2 * (SQRT_STEPS - 1 - i) : 0;
		always_ff @(posedge clk) begin
			if (adv) begin
				if (!y_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_turn(i);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_turn(i);
				end
				if (i < SQRT_STEPS) begin
					if (rem_s[i] >= res_s[i] + (SQ_W'(1) << BP)) begin
						rem_s[i+1] <= rem_s[i] - res_s[i] - (SQ_W'(1) << BP);
						res_s[i+1] <= (res_s[i] >> 1) + (SQ_W'(1) << BP);
					end else begin
						rem_s[i+1] <= rem_s[i];
						res_s[i+1] <= res_s[i] >> 1;
					end
				end else begin
					rem_s[i+1] <= rem_s[i];
					res_s[i+1] <= res_s[i];
				end
			end
		end
	end

	logic [AFB:0] a_raw, a_fix;
	assign a_raw = (AFB+1)'(({1'b0, z_s[CORDIC_STEPS]} + 33'(1 << (31 - AFB))) >> (32 - AFB));
	always_comb begin
		a_fix = a_raw;
		if (!it_s[CORDIC_STEPS].dy[DIFF_W-1] && a_raw >= (AFB+1)'(3 << (AFB - 2)))
			a_fix = '0;
		else if (it_s[CORDIC_STEPS].dy[DIFF_W-1] && a_raw < (AFB+1)'(1 << (AFB - 2)))
			a_fix = (AFB+1)'(1) << AFB;
	end

	logic [PW-AFB-1:0] sec_raw;
	logic [COUNT_W+3:0] cm1;
	assign sec_raw = p_s33[PW-1:AFB];
	assign cm1 = it_s[NS-1].count - 1'b1;

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s32 <= a_fix;
			d_s32 <= DIST_W'(res_s[CORDIC_STEPS]);
			zr_s32 <= it_s[CORDIC_STEPS].dx == '0 && it_s[CORDIC_STEPS].dy == '0;
			p_s33 <= PW'(a_s32) * PW'(it_s[CORDIC_STEPS+1].count);
			d_s33 <= d_s32;
			zr_s33 <= zr_s32;
			out_res.idx <= it_s[NS-1].idx;
			out_res.distance <= d_s33;
			out_res.elev <= it_s[NS-1].dz;
			if (zr_s33) out_res.sector <= '0;
			else if (sec_raw > cm1) out_res.sector <= SECTOR_W'(cm1);
			else out_res.sector <= SECTOR_W'(sec_raw);
		end
	end

	assign out_valid = v_s[NS];
endmodule
`default_nettype wire

>>> rtl/point_azimuth_sector_binner_unit.sv
`default_nettype none
// One point per cycle unless stalled; a 30-stage CORDIC/sqrt pipeline sets the latency.
// Output stall freezes the whole back pipeline; the 4-entry queue absorbs front beats.
// Reset (arst_n low, asynchronous): pipeline and queue empty, origin 0, sector count 8.
module point_azimuth_sector_binner_unit #(
	parameter int MAX_SECTORS = pasb_pkg::MAX_SECTORS_DEF,
	parameter int ANGLE_FRACTION_BITS = pasb_pkg::AFB_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [23:0] cfg_data,
	input wire logic s_tvalid,
	output logic s_tready,
	// point_index[19:0], point_x[43:20], point_y[67:44], point_z[91:68]
	input wire logic [95:0] s_tdata,
	output logic m_tvalid,
	input wire logic m_tready,
	// tagged_index[19:0], sector_index[27:20], distance[52:28], elevation[77:53]
	output logic [79:0] m_tdata
);
	import pasb_pkg::*;
	pasb_queue_ctl_t f2q, q2f;
	pasb_item_t fitem, qitem;
	pasb_result_t res;
	logic qv, qpop;

	pasb_front #(.MAX_SECTORS(MAX_SECTORS)) u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid(s_tvalid), .in_ready(s_tready),
		.in_idx(s_tdata[19:0]), .in_x(s_tdata[43:20]),
		.in_y(s_tdata[67:44]), .in_z(s_tdata[91:68]),
		.qctl_in(q2f), .qctl_out(f2q), .item(fitem)
	);

	pasb_queue u_queue (
		.clk, .arst_n, .ctl_in(f2q), .ctl_out(q2f), .wr_item(fitem),
		.rd_valid(qv), .rd_pop(qpop), .rd_item(qitem)
	);

	pasb_back #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_back (
		.clk, .arst_n, .q_valid(qv), .q_pop(qpop), .q_item(qitem),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
	);

	assign m_tdata = {2'b0, res.elev, res.distance, res.sector, res.idx};
endmodule
`default_nettype wire

>>> rtl/pasb_checker.sv
`default_nettype none
module pasb_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tready,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [79:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("stalled beat changed");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[79:78] == 2'b00) else $error("pad bits set");
	a_dist: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[52:28] <= 25'd29058991) else $error("distance out of range");
	a_rst: assert property (@(posedge clk) !arst_n |=> !m_tvalid) else $error("valid in reset");
	a_rdy: assert property (@(posedge clk) !arst_n |=> s_tready) else $error("not ready after reset");
endmodule

bind point_azimuth_sector_binner_unit pasb_checker u_pasb_checker (
	.clk, .arst_n, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import pasb_pkg::*;

	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic [19:0] idx;
		logic [7:0] sector;
		logic [24:0] distance;
		logic [24:0] elev;
	} bin_result_t;

	// Sector binner prediction and pending-result store
	class SectorScoreboard;
		logic signed [23:0] org_x, org_y, org_z;
		logic [8:0] sec_count;
		bin_result_t pending[$];
		int errors;

		function new();
			org_x = 0; org_y = 0; org_z = 0; sec_count = 9'd8; errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [23:0] val);
			case (idx)
				REG_ORIGIN_X: org_x = val;
				REG_ORIGIN_Y: org_y = val;
				REG_ORIGIN_Z: org_z = val;
				REG_SECTOR_COUNT: sec_count = val[8:0];
				default: ;
			endcase
		endfunction

		function logic [63:0] int_sqrt(logic [63:0] n);
			logic [63:0] res, bit_v;
			res = 0;
			bit_v = 64'd1 << 62;
			while (bit_v > n) bit_v >>= 2;
			while (bit_v != 0) begin
				if (n >= res + bit_v) begin
					n -= res + bit_v;
					res = (res >> 1) + bit_v;
				end else begin
					res >>= 1;
				end
				bit_v >>= 2;
			end
			return res;
		endfunction

		function logic [63:0] azimuth_turn(longint dx, longint dy);
			longint x, y, xs, ys;
			logic [31:0] ang;
			logic [63:0] a;
			ang = 0;
			if (dx < 0) begin
				x = -dx; y = -dy; ang = 32'h80000000;
			end else begin
				x = dx; y = dy;
			end
			x = x <<< 32;
			y = y <<< 32;
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x = x + ys; y = y - xs; ang = ang + atan_turn(i);
				end else begin
					x = x - ys; y = y + xs; ang = ang - atan_turn(i);
				end
			end
			a = ({32'd0, ang} + 64'd32768) >> 16;
			if (dy >= 0 && a >= 64'd49152) a = 0;
			else if (dy < 0 && a < 64'd16384) a = 64'd65536;
			return a;
		endfunction

		function void note_point(logic [95:0] beat);
			longint dx, dy, dz, cnt;
			logic [63:0] sec, sq;
			bin_result_t r;
			dx = longint'($signed(beat[43:20])) - longint'(org_x);
			dy = longint'($signed(beat[67:44])) - longint'(org_y);
			dz = longint'($signed(beat[91:68])) - longint'(org_z);
			cnt = sec_count;
			if (cnt == 0) cnt = 1;
			if (cnt > 256) cnt = 256;
			sec = 0;
			if (dx != 0 || dy != 0) begin
				sec = (azimuth_turn(dx, dy) * cnt) >> 16;
				if (sec > cnt - 1) sec = cnt - 1;
			end
			sq = dx * dx + dy * dy + dz * dz;
			r.idx = beat[19:0];
			r.sector = sec[7:0];
			r.distance = 25'(int_sqrt(sq));
			r.elev = 25'(dz);
			pending.insert(pending.size(), r);
		endfunction

		function void check_result(logic [79:0] beat);
			bin_result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result beat %h", beat);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (beat[19:0] !== e.idx) begin
				$error("tagged_index exp %0d got %0d", e.idx, beat[19:0]); errors++;
			end
			if (beat[27:20] !== e.sector) begin
				$error("sector_index exp %0d got %0d", e.sector, beat[27:20]); errors++;
			end
			if (beat[52:28] !== e.distance) begin
				$error("distance exp %0d got %0d", e.distance, beat[52:28]); errors++;
			end
			if (beat[77:53] !== e.elev) begin
				$error("elevation exp %0d got %0d", $signed(e.elev),
					$signed(beat[77:53]));
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [1:0] cfg_index = 0;
	logic [23:0] cfg_data = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [95:0] s_tdata = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [79:0] m_tdata;

	SectorScoreboard sb = new();
	int idle_cycles = 0;
	bit hold_output = 0;
	int n_points = 0;

	always #2 clk = ~clk;

	point_azimuth_sector_binner_unit DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// receiver: random stalls, one long hold-off on request
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			if (hold_output) begin
				m_tready <= 0;
				repeat (300) @(posedge clk);
				hold_output = 0;
			end
			g = gap_len();
			if (g > 0) begin
				m_tready <= 0;
				repeat (g) @(posedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [23:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, val);
	endtask

	task automatic send_point(logic [23:0] x, logic [23:0] y, logic [23:0] z, bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			s_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {4'd0, z, y, x, 20'($urandom)};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_point(s_tdata);
		n_points++;
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic logic [23:0] rand_coord();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2) return ($urandom_range(0, 1)) ? 24'h7FFFFF : 24'h800000;
		if (r < 5) return 24'($signed($urandom_range(0, 4000)) - 2000);
		return 24'($urandom);
	endfunction

	task automatic random_points(int n, bit gaps);
		for (int i = 0; i < n; i++) send_point(rand_coord(), rand_coord(), rand_coord(), gaps);
	endtask

	initial begin
		logic [23:0] mx, mn;
		mx = 24'h7FFFFF;
		mn = 24'h800000;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: axes, diagonals, origin, extremes at reset settings
		send_point(0, 0, 0, 0);
		send_point(0, 0, mx, 0);
		send_point(100, 0, 0, 0);
		send_point(0, 100, 0, 0);
		send_point(-24'sd100, 0, mn, 0);
		send_point(0, -24'sd100, 0, 0);
		send_point(100, 100, 5, 0);
		send_point(-24'sd100, 100, 0, 0);
		send_point(-24'sd100, -24'sd100, 0, 0);
		send_point(100, -24'sd1, 0, 0);
		send_point(100, 1, 0, 0);
		send_point(mx, mx, mx, 0);
		send_point(mn, mn, mn, 0);
		send_point(mn, 0, 0, 0);
		send_point(mx, -24'sd1, 0, 0);
		drain();

		// opposite-corner origin gives largest differences
		write_reg(REG_ORIGIN_X, mn);
		write_reg(REG_ORIGIN_Y, mx);
		write_reg(REG_ORIGIN_Z, mn);
		write_reg(REG_SECTOR_COUNT, 9'd256);
		send_point(mx, mn, mx, 0);
		send_point(mn, mx, mn, 0);
		send_point(mx, mx, mx, 0);
		random_points(60, 1);
		drain();

		write_reg(REG_SECTOR_COUNT, 9'd0);
		write_reg(REG_ORIGIN_X, 24'd0);
		write_reg(REG_ORIGIN_Y, 24'd0);
		random_points(40, 1);
		drain();

		write_reg(REG_SECTOR_COUNT, 9'd511);
		write_reg(REG_ORIGIN_Z, mx);
		random_points(80, 1);
		drain();

		write_reg(REG_SECTOR_COUNT, 9'd1);
		random_points(40, 1);
		drain();

		// long output hold-off while input keeps offering
		write_reg(REG_SECTOR_COUNT, 9'd7);
		write_reg(REG_ORIGIN_X, 24'($urandom));
		write_reg(REG_ORIGIN_Y, 24'($urandom));
		write_reg(REG_ORIGIN_Z, 24'($urandom));
		hold_output = 1;
		random_points(100, 0);
		drain();

		for (int p = 0; p < 4; p++) begin
			write_reg(REG_SECTOR_COUNT, 9'($urandom_range(1, 300)));
			write_reg(REG_ORIGIN_X, 24'($signed($urandom_range(0, 2000)) - 1000));
			write_reg(REG_ORIGIN_Y, 24'($signed($urandom_range(0, 2000)) - 1000));
			random_points(90, p[0]);
			drain();
		end

		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
